@@ rtl/point_in_polygon_test_defines.svh @@
// Assertion macros for the point-in-polygon tester
`ifndef POINT_IN_POLYGON_TEST_DEFINES_SVH
`define POINT_IN_POLYGON_TEST_DEFINES_SVH

`ifndef SYNTHESIS
`define PIP_ASSERT_SAME(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("pip assertion failed");
`define PIP_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("pip assertion failed");
`else
`define PIP_ASSERT_SAME(label, clk, rstn, ante, cons)
`define PIP_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif

`endif

@@ rtl/pip_pkg.sv @@
// Shared types and codes for the point-in-polygon tester
package pip_pkg;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_TEST = 1'b1;

  typedef struct packed {
    logic vld;
    logic test;
    logic ovf;
    logic par;
  } ctl_t;

endpackage

@@ rtl/point_in_polygon_test.sv @@
// Point-in-polygon tester: vertex cell chain with even-odd crossing count
// Throughput: one word per cycle while a held result on m_axis does not stall
// the chain; each word passes through all MAX_VERTICES+1 cells, each running
// a four-stage edge test (differences, split products, sums, compare).
// Reset clears vertex count, overflow flag and all valid bits at once;
// vertex storage is not cleared.
`include "point_in_polygon_test_defines.svh"

module point_in_polygon_test #(
  parameter int MAX_VERTICES = 64,
  parameter int COORD_BITS   = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // coord_x, coord_y
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]     s_axis_tdata_i,
  // command, first_vertex
  input  logic [1:0]                            s_axis_tuser_i,
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // inside_res, vertices_dropped
  output logic [7:0]                            m_axis_tdata_o
);

  localparam int CB = COORD_BITS;
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int NC = MAX_VERTICES + 1;

  pip_pkg::ctl_t        ctl_w [NC+1];
  logic [CW-1:0]        cnt_w [NC+1];
  logic signed [CB-1:0] px_w  [NC+1];
  logic signed [CB-1:0] py_w  [NC+1];
  logic signed [CB-1:0] v0x_w [NC+1];
  logic signed [CB-1:0] v0y_w [NC+1];
  logic signed [CB-1:0] prx_w [NC+1];
  logic signed [CB-1:0] pry_w [NC+1];

  logic          en;
  logic          acc;
  logic          cmd;
  logic          first;
  logic [CW-1:0] cnt_q, cnt_d, cnt_base;
  logic          ovf_q, ovf_d, ovf_base;
  pip_pkg::ctl_t ctl_in;
  logic [CW-1:0] cnt_in;
  logic          out_vld_q;
  logic          out_in_q;
  logic          out_dr_q;
  logic          full_load;
  logic          tail_test;

  assign en              = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign acc             = s_axis_tvalid_i && en;
  assign cmd             = s_axis_tuser_i[0];
  assign first           = s_axis_tuser_i[1];
  assign cnt_base        = first ? '0 : cnt_q;
  assign ovf_base        = first ? 1'b0 : ovf_q;

  always_comb begin
    cnt_d  = cnt_q;
    ovf_d  = ovf_q;
    ctl_in = '0;
    cnt_in = cnt_q;
    if (acc) begin
      if (cmd == pip_pkg::CMD_TEST) begin
        ctl_in.vld  = 1'b1;
        ctl_in.test = 1'b1;
        ctl_in.ovf  = ovf_q;
      end else if (cnt_base < CW'(MAX_VERTICES)) begin
        ctl_in.vld = 1'b1;
        cnt_in     = cnt_base;
        cnt_d      = cnt_base + 1'b1;
        ovf_d      = ovf_base;
      end else begin
        // drop vertex past capacity
        cnt_d = cnt_base;
        ovf_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
    end
  end

  assign ctl_w[0] = ctl_in;
  assign cnt_w[0] = cnt_in;
  assign px_w[0]  = $signed(s_axis_tdata_i[CB-1:0]);
  assign py_w[0]  = $signed(s_axis_tdata_i[2*CB-1:CB]);
  assign v0x_w[0] = '0;
  assign v0y_w[0] = '0;
  assign prx_w[0] = '0;
  assign pry_w[0] = '0;

  for (genvar k = 0; k < NC; k++) begin : g_cell
    pip_cell #(
      .IDX (k),
      .CB  (CB),
      .CW  (CW)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .ctl_i  (ctl_w[k]),
      .cnt_i  (cnt_w[k]),
      .px_i   (px_w[k]),
      .py_i   (py_w[k]),
      .v0x_i  (v0x_w[k]),
      .v0y_i  (v0y_w[k]),
      .prx_i  (prx_w[k]),
      .pry_i  (pry_w[k]),
      .ctl_o  (ctl_w[k+1]),
      .cnt_o  (cnt_w[k+1]),
      .px_o   (px_w[k+1]),
      .py_o   (py_w[k+1]),
      .v0x_o  (v0x_w[k+1]),
      .v0y_o  (v0y_w[k+1]),
      .prx_o  (prx_w[k+1]),
      .pry_o  (pry_w[k+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= ctl_w[NC].vld && ctl_w[NC].test;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_in_q <= ctl_w[NC].par;
      out_dr_q <= ctl_w[NC].ovf;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {6'b0, out_dr_q, out_in_q};

  assign full_load = acc && (cmd == pip_pkg::CMD_LOAD) && !first &&
                     (cnt_q == CW'(MAX_VERTICES));
  assign tail_test = en && ctl_w[NC].vld && ctl_w[NC].test;

  `PIP_ASSERT_SAME(a_ovf_full, clk_i, rst_ni, ovf_q, cnt_q == CW'(MAX_VERTICES))
  `PIP_ASSERT_NEXT(a_full_load_sets_ovf, clk_i, rst_ni, full_load, ovf_q)
  `PIP_ASSERT_NEXT(a_tail_test_out, clk_i, rst_ni, tail_test, m_axis_tvalid_o)

endmodule

@@ rtl/pip_cell.sv @@
// One polygon vertex cell: stores a vertex and tests one edge per passing word
module pip_cell #(
  parameter int IDX = 0,
  parameter int CB  = 32,
  parameter int CW  = 7
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  pip_pkg::ctl_t        ctl_i,
  input  logic [CW-1:0]        cnt_i,
  input  logic signed [CB-1:0] px_i,
  input  logic signed [CB-1:0] py_i,
  input  logic signed [CB-1:0] v0x_i,
  input  logic signed [CB-1:0] v0y_i,
  input  logic signed [CB-1:0] prx_i,
  input  logic signed [CB-1:0] pry_i,
  output pip_pkg::ctl_t        ctl_o,
  output logic [CW-1:0]        cnt_o,
  output logic signed [CB-1:0] px_o,
  output logic signed [CB-1:0] py_o,
  output logic signed [CB-1:0] v0x_o,
  output logic signed [CB-1:0] v0y_o,
  output logic signed [CB-1:0] prx_o,
  output logic signed [CB-1:0] pry_o
);

  localparam int W  = CB + 1;
  localparam int H  = W / 2;
  localparam int PW = 2 * W;

  logic signed [CB-1:0] vx_q, vy_q;

  logic                 act;
  logic                 own;
  logic signed [CB-1:0] ex, ey;
  logic signed [W-1:0]  a_d, b_d, c_d, d_d;
  logic                 hop_d;

  pip_pkg::ctl_t        ctl1_q, ctl2_q, ctl3_q, ctl4_q;
  logic [CW-1:0]        cnt1_q, cnt2_q, cnt3_q, cnt4_q;
  logic signed [CB-1:0] px1_q, py1_q, v0x1_q, v0y1_q, prx1_q, pry1_q;
  logic signed [CB-1:0] px2_q, py2_q, v0x2_q, v0y2_q, prx2_q, pry2_q;
  logic signed [CB-1:0] px3_q, py3_q, v0x3_q, v0y3_q, prx3_q, pry3_q;
  logic signed [CB-1:0] px4_q, py4_q, v0x4_q, v0y4_q, prx4_q, pry4_q;
  logic signed [W-1:0]  a_q, b_q, c_q, d_q;
  logic                 hop1_q, hop2_q, hop3_q;
  logic                 up1_q, up2_q, up3_q;
  logic signed [W+H:0]     pl1_q, pl2_q;
  logic signed [2*W-H-1:0] ph1_q, ph2_q;
  logic signed [PW-1:0]    p1_q, p2_q;
  logic                    hit;

  // store vertex when a load word for this slot passes
  always_ff @(posedge clk_i) begin
    if (en_i && ctl_i.vld && !ctl_i.test && (cnt_i == CW'(IDX))) begin
      vx_q <= px_i;
      vy_q <= py_i;
    end
  end

  always_comb begin
    act   = (IDX > 0) && (CW'(IDX) <= cnt_i);
    own   = CW'(IDX) < cnt_i;
    ex    = own ? vx_q : v0x_i;
    ey    = own ? vy_q : v0y_i;
    a_d   = W'(px_i) - W'(prx_i);
    b_d   = W'(ey) - W'(pry_i);
    c_d   = W'(ex) - W'(prx_i);
    d_d   = W'(py_i) - W'(pry_i);
    hop_d = act && ((pry_i > py_i) != (ey > py_i));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
      ctl3_q <= '0;
      ctl4_q <= '0;
    end else if (en_i) begin
      ctl1_q <= ctl_i;
      ctl2_q <= ctl1_q;
      ctl3_q <= ctl2_q;
      ctl4_q <= {ctl3_q.vld, ctl3_q.test, ctl3_q.ovf,
                 ctl3_q.par ^ (ctl3_q.vld && ctl3_q.test && hit)};
    end
  end

  assign hit = hop3_q && (up3_q ? (p1_q < p2_q) : (p1_q > p2_q));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // stage 1: edge differences
      cnt1_q <= cnt_i;
      px1_q  <= px_i;
      py1_q  <= py_i;
      v0x1_q <= (IDX == 0) ? vx_q : v0x_i;
      v0y1_q <= (IDX == 0) ? vy_q : v0y_i;
      prx1_q <= ex;
      pry1_q <= ey;
      a_q    <= a_d;
      b_q    <= b_d;
      c_q    <= c_d;
      d_q    <= d_d;
      hop1_q <= hop_d;
      up1_q  <= ey > pry_i;
      // stage 2: partial products
      cnt2_q <= cnt1_q;
      px2_q  <= px1_q;
      py2_q  <= py1_q;
      v0x2_q <= v0x1_q;
      v0y2_q <= v0y1_q;
      prx2_q <= prx1_q;
      pry2_q <= pry1_q;
      pl1_q  <= a_q * $signed({1'b0, b_q[H-1:0]});
      ph1_q  <= a_q * $signed(b_q[W-1:H]);
      pl2_q  <= c_q * $signed({1'b0, d_q[H-1:0]});
      ph2_q  <= c_q * $signed(d_q[W-1:H]);
      hop2_q <= hop1_q;
      up2_q  <= up1_q;
      // stage 3: full products
      cnt3_q <= cnt2_q;
      px3_q  <= px2_q;
      py3_q  <= py2_q;
      v0x3_q <= v0x2_q;
      v0y3_q <= v0y2_q;
      prx3_q <= prx2_q;
      pry3_q <= pry2_q;
      p1_q   <= (PW'(ph1_q) <<< H) + PW'(pl1_q);
      p2_q   <= (PW'(ph2_q) <<< H) + PW'(pl2_q);
      hop3_q <= hop2_q;
      up3_q  <= up2_q;
      // stage 4: compare and update parity
      cnt4_q <= cnt3_q;
      px4_q  <= px3_q;
      py4_q  <= py3_q;
      v0x4_q <= v0x3_q;
      v0y4_q <= v0y3_q;
      prx4_q <= prx3_q;
      pry4_q <= pry3_q;
    end
  end

  assign ctl_o = ctl4_q;
  assign cnt_o = cnt4_q;
  assign px_o  = px4_q;
  assign py_o  = py4_q;
  assign v0x_o = v0x4_q;
  assign v0y_o = v0y4_q;
  assign prx_o = prx4_q;
  assign pry_o = pry4_q;

endmodule
